// ===== rtl/core/ridmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// ridmtf_pkg
// Shared types and codes for the recent id move-to-front list.
// ----------------------------------------------------------------------------
package ridmtf_pkg;

   // fixed widths of the channel fields
   localparam int FUNC_W = 2;
   localparam int ID_W   = 32;
   localparam int POS_W  = 4;
   localparam int LEN_W  = 5;

   typedef logic [FUNC_W-1:0] func_type;

   // operation codes; the fourth code is a no-op
   localparam func_type FUNC_TOUCH  = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_READ   = 2'd2;

   typedef struct packed {
      func_type           func;
      logic [ID_W-1:0]    item_id;
      logic [POS_W-1:0]   position;
   } req_payload_type;

   typedef struct packed {
      logic               entry_valid;
      logic [ID_W-1:0]    entry_id;
      logic               was_present;
      logic               evicted_valid;
      logic [ID_W-1:0]    evicted_id;
      logic [LEN_W-1:0]   list_length;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // request beat taken this cycle
      logic scan;     // walk the list
      logic fetch;    // read the entry at the requested position
      logic finish;   // commit state and load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type req_func;   // opcode of the beat on the request channel
      logic     scan_done;
      logic     out_free;   // result register can take a new beat
   } status_type;

endpackage

// ===== rtl/core/ridmtf_if.sv =====
// ----------------------------------------------------------------------------
// ridmtf_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface ridmtf_req_if;
   import ridmtf_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ridmtf_rsp_if;
   import ridmtf_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/recent_id_move_to_front_list.sv =====
// ----------------------------------------------------------------------------
// recent_id_move_to_front_list
// Bounded most-recently-used id list with move-to-front, remove and read.
// ----------------------------------------------------------------------------
// Holds up to LIST_DEPTH ids, most recent at position 0. A touch (func 0)
// moves the id to the front; a new id on a full list pushes the tail out and
// reports it in evicted_id. A remove (func 1) deletes the id if present and
// closes the gap. A read (func 2) returns the entry at position, or
// entry_valid 0 past the current length. Code 3 is a no-op that only reports
// list_length. Every request beat yields exactly one result beat, in order.
// Ids keep their low ID_BITS bits. Entries live in a RAM with one write port
// and one registered read port (one write and one read per cycle) that is
// walked one entry per cycle; a touch or remove walks the list (a touch stops
// at the first hit), a read fetches one entry and a no-op goes straight to
// the commit. One request is worked on at a time; the next request beat is
// taken while a result beat waits in the output register; a stalled result
// beat holds the commit of the following request.
// No clearing pass after reset: only the first list_length entries are read.
// ----------------------------------------------------------------------------
module recent_id_move_to_front_list #(
   parameter int LIST_DEPTH = 16,
   parameter int ID_BITS    = 32
) (
   input  logic          clock,
   input  logic          reset,
   ridmtf_req_if.sink    req_chan,
   ridmtf_rsp_if.source  rsp_chan
);
   import ridmtf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: idle -> scan | fetch -> finish, or idle -> finish for a no-op
   ridmtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // entry RAM, move-to-front carry, length counter, result register
   ridmtf_dp #(
      .LIST_DEPTH (LIST_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== rtl/core/ridmtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ridmtf_ctrl
// Sequencer: takes a request beat, runs the scan or fetch (none for a no-op), then commits.
// ----------------------------------------------------------------------------
module ridmtf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ridmtf_pkg::status_type  status,
   output ridmtf_pkg::cmd_type     cmd
);
   import ridmtf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   always_comb begin
      cmd.accept = req_valid && ready_ff;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.fetch  = (state_ff == ST_FETCH);
      cmd.finish = (state_ff == ST_FINISH) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if (status.req_func == FUNC_TOUCH || status.req_func == FUNC_REMOVE) begin
                  state_in = ST_SCAN;
               end else if (status.req_func == FUNC_READ) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_FINISH;   // no-op code
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FETCH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> ready_ff)
      else $error("not ready after commit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !ready_ff)
      else $error("still ready after taking a beat");

   a_fetch_then_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (state_ff == ST_FINISH))
      else $error("fetch not followed by commit");

endmodule

// ===== rtl/core/ridmtf_dp.sv =====
// ----------------------------------------------------------------------------
// ridmtf_dp
// Entry RAM, scan pointer, carry register, length counter, result register.
// ----------------------------------------------------------------------------
module ridmtf_dp #(
   parameter int LIST_DEPTH = 16,
   parameter int ID_BITS    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ridmtf_pkg::req_payload_type  req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ridmtf_pkg::rsp_payload_type  rsp_payload,
   input  ridmtf_pkg::cmd_type          cmd,
   output ridmtf_pkg::status_type       status
);
   import ridmtf_pkg::*;

   localparam int IW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int LW = (CW > LEN_W) ? CW : LEN_W;
   localparam int XW = (ID_BITS > ID_W) ? ID_BITS : ID_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   function automatic logic [ID_W-1:0] to_port(input logic [ID_BITS-1:0] v);
      logic [XW-1:0] x;
      x = XW'(v);
      return x[ID_W-1:0];
   endfunction

   logic [ID_BITS-1:0] entry_ram [LIST_DEPTH];

   // operation registers
   func_type           func_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [POS_W-1:0]   pos_ff;

   // scan state
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic               dvld_ff, dvld_in;
   logic [IW-1:0]      d_idx_ff, d_idx_in;
   logic [ID_BITS-1:0] carry_ff, carry_in;
   logic               found_ff, found_in;
   logic [ID_BITS-1:0] rd_data_ff;

   logic [CW-1:0]      count_ff, count_in;

   rsp_payload_type    rsp_data_ff, rsp_next;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [XW-1:0]      req_id_x;
   logic [PW-1:0]      pos_x;
   logic [LW-1:0]      len_x;
   logic               is_touch, is_remove;
   logic               pos_in_range, has_room;
   logic               process, hit, issue_scan, issue_fetch;
   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_idx;
   logic [ID_BITS-1:0] wr_data;
   logic               out_free;

   assign req_id_x = XW'(req_payload.item_id);

   always_comb begin
      is_touch     = (func_ff == FUNC_TOUCH);
      is_remove    = (func_ff == FUNC_REMOVE);
      pos_x        = PW'(pos_ff);
      pos_in_range = pos_x < PW'(count_ff);
      has_room     = count_ff < DEPTH_C;

      // read data from the previous cycle; a touch stops at the first hit
      process     = cmd.scan && dvld_ff && (is_remove || !found_ff);
      hit         = process && (rd_data_ff == id_ff);
      issue_scan  = cmd.scan && !(is_touch && (found_ff || hit)) && (rd_idx_ff < count_ff);
      issue_fetch = cmd.fetch && pos_in_range;
      rd_en       = issue_scan || issue_fetch;
      rd_addr     = issue_fetch ? pos_x[IW-1:0] : rd_idx_ff[IW-1:0];

      rd_idx_in = rd_idx_ff;
      dvld_in   = issue_scan;
      d_idx_in  = issue_scan ? rd_idx_ff[IW-1:0] : d_idx_ff;
      carry_in  = carry_ff;
      found_in  = found_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_idx    = d_idx_ff;
      wr_data   = carry_ff;
      rsp_next  = '0;

      if (cmd.accept) begin
         rd_idx_in = '0;
         carry_in  = req_id_x[ID_BITS-1:0];
         found_in  = 1'b0;
      end

      if (issue_scan) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end

      if (process) begin
         if (is_touch) begin
            // forward pass: each slot takes its predecessor, the id lands up front
            wr_en    = 1'b1;
            wr_idx   = d_idx_ff;
            wr_data  = carry_ff;
            carry_in = rd_data_ff;
            if (hit) begin
               found_in = 1'b1;
            end
         end else if (found_ff) begin
            // close up behind the removed entry
            wr_en   = 1'b1;
            wr_idx  = d_idx_ff - IW'(1);
            wr_data = rd_data_ff;
         end else if (hit) begin
            found_in = 1'b1;
         end
      end

      if (cmd.finish) begin
         unique case (func_ff)
            FUNC_TOUCH: begin
               rsp_next.was_present = found_ff;
               if (!found_ff) begin
                  if (has_room) begin
                     wr_en    = 1'b1;
                     wr_idx   = count_ff[IW-1:0];
                     wr_data  = carry_ff;
                     count_in = count_ff + CW'(1);
                  end else begin
                     // carry holds the old tail
                     rsp_next.evicted_valid = 1'b1;
                     rsp_next.evicted_id    = to_port(carry_ff);
                  end
               end
            end
            FUNC_REMOVE: begin
               rsp_next.was_present = found_ff;
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
               end
            end
            FUNC_READ: begin
               rsp_next.entry_valid = pos_in_range;
               if (pos_in_range) begin
                  rsp_next.entry_id = to_port(rd_data_ff);
               end
            end
            default: begin
            end
         endcase
      end

      len_x                = LW'(count_in);
      rsp_next.list_length = len_x[LEN_W-1:0];

      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         dvld_ff      <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         dvld_ff      <= dvld_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_payload.func;
         id_ff   <= req_id_x[ID_BITS-1:0];
         pos_ff  <= req_payload.position;
      end
      carry_ff <= carry_in;
      d_idx_ff <= d_idx_in;
      if (cmd.finish) begin
         rsp_data_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_ram[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      status.req_func  = req_payload.func;
      status.scan_done = (is_touch && found_ff) || ((rd_idx_ff == count_ff) && !dvld_ff);
      status.out_free  = out_free;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("length above depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.finish |=> $stable(count_ff))
      else $error("length changed outside commit");

   a_remove_shrink: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && is_remove && found_ff) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove hit did not shorten list");

endmodule

// ===== tb/tb_recent_id_move_to_front_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_recent_id_move_to_front_list
// Self-checking bench for the move-to-front recent id list.
// ----------------------------------------------------------------------------
// A directed table walks the corner cases: an empty list, the no-op code,
// extreme ids, filling the list, touching a listed id on a full list, an
// eviction, a read of the last slot and removes. A random phase follows,
// drawing ids from a small per-phase pool so touches and removes hit listed
// ids, with the op mix changed per phase so the list swings between empty
// and full. Every request beat is run through a local model of the list and
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_recent_id_move_to_front_list;
   import ridmtf_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int PHASES      = 10;
   localparam int PHASE_BEATS = 125;
   localparam int DRAIN_WAIT  = 64;     // > longest op (full list scan + overhead)
   localparam int IDLE_PCT    = 9;

   // the package leaves the fourth opcode unnamed; it is a no-op
   localparam func_type FUNC_NOOP = 2'd3;

   logic clock = 1'b0;
   logic reset;

   ridmtf_req_if req_bus ();
   ridmtf_rsp_if rsp_bus ();

   recent_id_move_to_front_list #(
      .LIST_DEPTH (LIST_DEPTH),
      .ID_BITS    (ID_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Local copy of the list: most recent id first, mru_len entries valid.
   // -------------------------------------------------------------------------
   logic [ID_W-1:0]  mru_ids [LIST_DEPTH];
   int               mru_len;
   rsp_payload_type  results_due [$];    // predicted result beats, oldest first
   int               mismatch_count;
   bit               steady_run;         // no idling on either side while set

   // directed table: the expected beat is only used where known is set
   typedef struct {
      req_payload_type beat;
      bit              known;
      rsp_payload_type want;
   } stim_row_type;

   stim_row_type     stim_table [$];
   logic [ID_W-1:0]  id_pool [$];

   // Applies one request to the local list and returns the result it yields.
   function automatic rsp_payload_type apply_list_op(req_payload_type r);
      rsp_payload_type o;
      int              hit;
      int              i;
      o   = '0;
      hit = -1;
      for (i = 0; i < mru_len; i++)
         if (hit < 0 && mru_ids[i] == r.item_id) hit = i;
      case (r.func)
         FUNC_TOUCH: begin
            if (hit >= 0) begin
               // listed id: entries in front of it slide back one slot
               o.was_present = 1'b1;
               for (i = hit; i > 0; i--) mru_ids[i] = mru_ids[i-1];
            end else if (mru_len == LIST_DEPTH) begin
               // new id on a full list: the tail falls out
               o.evicted_valid = 1'b1;
               o.evicted_id    = mru_ids[LIST_DEPTH-1];
               for (i = LIST_DEPTH - 1; i > 0; i--) mru_ids[i] = mru_ids[i-1];
            end else begin
               for (i = mru_len; i > 0; i--) mru_ids[i] = mru_ids[i-1];
               mru_len++;
            end
            mru_ids[0] = r.item_id;
         end
         FUNC_REMOVE: begin
            if (hit >= 0) begin
               o.was_present = 1'b1;
               for (i = hit; i + 1 < mru_len; i++) mru_ids[i] = mru_ids[i+1];
               mru_len--;
            end
         end
         FUNC_READ: begin
            if (r.position < mru_len) begin
               o.entry_valid = 1'b1;
               o.entry_id    = mru_ids[r.position];
            end
         end
         default: ;   // no-op: only the length is reported
      endcase
      o.list_length = mru_len[LEN_W-1:0];
      return o;
   endfunction

   task automatic add_row(input func_type f, input logic [ID_W-1:0] id,
                          input logic [POS_W-1:0] pos);
      stim_row_type row;
      row.beat  = '{func: f, item_id: id, position: pos};
      row.known = 1'b0;
      row.want  = '0;
      stim_table.push_back(row);
   endtask

   task automatic add_known(input func_type f, input logic [ID_W-1:0] id,
                            input logic [POS_W-1:0] pos, input logic ent_v,
                            input logic [ID_W-1:0] ent_id, input logic pres,
                            input logic ev_v, input logic [ID_W-1:0] ev_id,
                            input logic [LEN_W-1:0] len);
      stim_row_type row;
      row.beat  = '{func: f, item_id: id, position: pos};
      row.known = 1'b1;
      row.want  = '{entry_valid: ent_v, entry_id: ent_id, was_present: pres,
                    evicted_valid: ev_v, evicted_id: ev_id, list_length: len};
      stim_table.push_back(row);
   endtask

   // Drives one request beat, with a random gap in front of it, and records
   // the expected result once the beat is taken.
   task automatic send_beat(input req_payload_type b, input bit known,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= b;
      do @(posedge clock); while (!req_bus.ready);
      // beat taken at this edge; the model moves on regardless of the table
      predicted = apply_list_op(b);
      results_due.push_back(known ? want : predicted);
   endtask

   // Ids for touch/remove: mostly from the phase pool so they hit the list.
   function automatic logic [ID_W-1:0] pick_id();
      if (id_pool.size() != 0 && $urandom_range(99) < 85)
         return id_pool[$urandom_range(id_pool.size() - 1)];
      return $urandom;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: random backpressure, and every taken beat checked in order.
   // -------------------------------------------------------------------------
   initial rsp_bus.ready = 1'b0;

   always @(posedge clock) begin
      rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
   end

   rsp_payload_type head_want;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_due.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, got %h",
                     $time, rsp_bus.payload);
            mismatch_count++;
         end else begin
            head_want = results_due.pop_front();
            check_field("entry_valid", 32'(head_want.entry_valid),
                        32'(rsp_bus.payload.entry_valid));
            check_field("entry_id", 32'(head_want.entry_id),
                        32'(rsp_bus.payload.entry_id));
            check_field("was_present", 32'(head_want.was_present),
                        32'(rsp_bus.payload.was_present));
            check_field("evicted_valid", 32'(head_want.evicted_valid),
                        32'(rsp_bus.payload.evicted_valid));
            check_field("evicted_id", 32'(head_want.evicted_id),
                        32'(rsp_bus.payload.evicted_id));
            check_field("list_length", 32'(head_want.list_length),
                        32'(rsp_bus.payload.list_length));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      req_payload_type b;
      int              touch_pct;
      int              remove_pct;
      int              pick;
      int              k;
      int              phase;
      int              n;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      mismatch_count  = 0;
      mru_len         = 0;
      steady_run      = 1'b0;
      foreach (mru_ids[i]) mru_ids[i] = '0;

      // --- directed table ---
      // empty list: read, remove of an absent id, no-op with all ones
      add_known(FUNC_READ,   32'h0000_0000, 4'd0,  1'b0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0);
      add_known(FUNC_REMOVE, 32'h1234_5678, 4'd0,  1'b0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0);
      add_known(FUNC_NOOP,   32'hFFFF_FFFF, 4'd15, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0);
      // extreme ids, then read the older one back
      add_known(FUNC_TOUCH,  32'h0000_0000, 4'd0,  1'b0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd1);
      add_known(FUNC_TOUCH,  32'hFFFF_FFFF, 4'd15, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd2);
      add_known(FUNC_READ,   32'hFFFF_FFFF, 4'd1,  1'b1, 32'h0, 1'b0, 1'b0, 32'h0, 5'd2);
      // listed id moves to the front, nothing else changes
      add_known(FUNC_TOUCH,  32'h0000_0000, 4'd0,  1'b0, 32'h0, 1'b1, 1'b0, 32'h0, 5'd2);
      // fill the list with walking-one ids; all-ones ends up at the tail
      for (k = 0; k < LIST_DEPTH - 2; k++)
         add_row(FUNC_TOUCH, 32'h1 << (2 * k + 1), 4'(k));
      // full list, listed tail touched: moves up, no eviction
      add_known(FUNC_TOUCH,  32'hFFFF_FFFF, 4'd0,  1'b0, 32'h0, 1'b1, 1'b0, 32'h0, 5'd16);
      // new id on a full list: tail is evicted
      add_row(FUNC_TOUCH,  32'hA5A5_5A5A, 4'd0);
      add_row(FUNC_READ,   32'h0000_0000, 4'd15);
      add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 4'd0);
      add_row(FUNC_REMOVE, 32'h0000_0000, 4'd0);   // just evicted: absent
      add_row(FUNC_READ,   32'h0000_0000, 4'd15);  // one past the length

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         send_beat(stim_table[i].beat, stim_table[i].known, stim_table[i].want);

      // --- random phases ---
      // Each phase gets a fresh id pool and op mix. Small pools keep the list
      // short with many hits; large pools and heavy touching push it to full.
      for (phase = 0; phase < PHASES; phase++) begin
         steady_run = (phase == 4 || phase == 5);
         id_pool.delete();
         n = $urandom_range(40, 3);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
               0:       id_pool.push_back(32'h0000_0000);
               1:       id_pool.push_back(32'hFFFF_FFFF);
               2:       id_pool.push_back(32'h1 << $urandom_range(31));
               default: id_pool.push_back($urandom);
            endcase
         end
         touch_pct  = $urandom_range(60, 30);
         remove_pct = $urandom_range(35, 10);

         for (n = 0; n < PHASE_BEATS; n++) begin
            pick       = $urandom_range(99);
            b.item_id  = pick_id();
            b.position = 4'($urandom_range(15));
            if (pick < touch_pct)                   b.func = FUNC_TOUCH;
            else if (pick < touch_pct + remove_pct) b.func = FUNC_REMOVE;
            else if (pick < 96)                     b.func = FUNC_READ;
            else                                    b.func = FUNC_NOOP;
            send_beat(b, 1'b0, '0);
         end
      end
      steady_run = 1'b0;
      req_bus.valid <= 1'b0;

      // wait for the last result, then give the block time to show any extra
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("** recent_id_move_to_front_list: PASSED **");
      else
         $display("** recent_id_move_to_front_list: FAILED **");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("%0t ns: timeout, %0d results still expected", $time, results_due.size());
      $display("** recent_id_move_to_front_list: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ridmtf_pkg.sv
rtl/core/ridmtf_if.sv
rtl/core/ridmtf_ctrl.sv
rtl/core/ridmtf_dp.sv
rtl/core/recent_id_move_to_front_list.sv
tb/tb_recent_id_move_to_front_list.sv
